FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the I2C bit-level master RTL
// Immediate-consequence and next-cycle implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define CHK_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Phase codes, command codes, register indexes, shared structs and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cbm_pkg;

  // Sequencer phases
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_ST_LOW  = 4'd1;
  localparam logic [3:0] PH_ST_END  = 4'd2;
  localparam logic [3:0] PH_SP_HIGH = 4'd3;
  localparam logic [3:0] PH_SP_END  = 4'd4;
  localparam logic [3:0] PH_WR_HI   = 4'd5;
  localparam logic [3:0] PH_WR_LO   = 4'd6;
  localparam logic [3:0] PH_WR_NEXT = 4'd7;
  localparam logic [3:0] PH_AK_HI   = 4'd8;
  localparam logic [3:0] PH_AK_POLL = 4'd9;
  localparam logic [3:0] PH_RD_HI   = 4'd10;
  localparam logic [3:0] PH_RD_SMP  = 4'd11;
  localparam logic [3:0] PH_RK_HI   = 4'd12;
  localparam logic [3:0] PH_RK_END  = 4'd13;

  // Command codes
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_WACK  = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // Delay lengths as shift amounts: 1, 2 and 4 units
  localparam logic [1:0] UNITS_1 = 2'd0;
  localparam logic [1:0] UNITS_2 = 2'd1;
  localparam logic [1:0] UNITS_4 = 2'd2;

  // Configuration register indexes
  localparam logic CFG_TICKS_PER_US = 1'b0;
  localparam logic CFG_ACK_TIMEOUT  = 1'b1;

  localparam logic [7:0]  TICKS_PER_US_RST = 8'd8;
  localparam logic [15:0] ACK_TIMEOUT_RST  = 16'd250;
  localparam logic [3:0]  BITS_PER_BYTE    = 4'd8;

  typedef struct packed {
    logic [7:0]  ticks_per_us;
    logic [15:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } step_in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive_en;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } result_t;

  // Reload value of the delay counter for a wait of 2**sh units.
  function automatic logic [9:0] wait_delay(input logic [1:0] sh, input logic [7:0] tpu);
    logic [9:0] d;
    d = {2'b00, tpu} << sh;
    return (d == 10'd0) ? 10'd0 : d - 10'd1;
  endfunction

endpackage

FILE: design/i2cbm_cfg.sv
// ----------------------------------------------------------------------------
// I2C bit-level master configuration registers
// Holds the delay unit length and the acknowledge timeout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cbm_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output i2cbm_pkg::cfg_t    cfg
);

  logic [7:0]  ticks_per_us;
  logic [15:0] ack_timeout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us <= i2cbm_pkg::TICKS_PER_US_RST;
      ack_timeout  <= i2cbm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == i2cbm_pkg::CFG_TICKS_PER_US) begin
        ticks_per_us <= cfg_data[7:0];
      end else begin
        ack_timeout <= cfg_data;
      end
    end
  end

  assign cfg.ticks_per_us = ticks_per_us;
  assign cfg.ack_timeout  = ack_timeout;

endmodule

FILE: design/i2cbm_core.sv
// ----------------------------------------------------------------------------
// I2C bit-level master sequencer
// Pin-phase state machine; advances one tick per fired item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cbm_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  i2cbm_pkg::step_in_t   step_in,
  input  i2cbm_pkg::cfg_t       cfg,
  output i2cbm_pkg::result_t    res_next
);

  logic [3:0]  phase, phase_next;
  logic [9:0]  delay_count, delay_count_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [15:0] timeout_count, timeout_count_next;
  logic        scl_level, scl_level_next;
  logic        sda_level, sda_level_next;
  logic        sda_dir, sda_dir_next;
  logic [7:0]  received_byte, received_byte_next;
  logic        fail_flag, fail_flag_next;
  logic        ack_choice, ack_choice_next;
  logic        done_next;
  logic [3:0]  bit_count_inc;

  assign bit_count_inc = bit_count + 4'd1;

  always_comb begin
    phase_next         = phase;
    delay_count_next   = delay_count;
    bit_count_next     = bit_count;
    shift_reg_next     = shift_reg;
    timeout_count_next = timeout_count;
    scl_level_next     = scl_level;
    sda_level_next     = sda_level;
    sda_dir_next       = sda_dir;
    received_byte_next = received_byte;
    fail_flag_next     = fail_flag;
    ack_choice_next    = ack_choice;
    done_next          = 1'b0;

    if (phase == i2cbm_pkg::PH_IDLE) begin
      if (step_in.cmd_valid) begin
        case (step_in.cmd)
          i2cbm_pkg::CMD_START: begin
            sda_dir_next     = 1'b1;
            sda_level_next   = 1'b1;
            scl_level_next   = 1'b1;
            delay_count_next = i2cbm_pkg::wait_delay(i2cbm_pkg::UNITS_4, cfg.ticks_per_us);
            phase_next       = i2cbm_pkg::PH_ST_LOW;
          end
          i2cbm_pkg::CMD_STOP: begin
            sda_dir_next     = 1'b1;
            scl_level_next   = 1'b0;
            sda_level_next   = 1'b0;
            delay_count_next = i2cbm_pkg::wait_delay(i2cbm_pkg::UNITS_4, cfg.ticks_per_us);
            phase_next       = i2cbm_pkg::PH_SP_HIGH;
          end
          i2cbm_pkg::CMD_WRITE: begin
            sda_dir_next     = 1'b1;
            scl_level_next   = 1'b0;
            bit_count_next   = 4'd0;
            sda_level_next   = step_in.tx_byte[7];
            shift_reg_next   = {step_in.tx_byte[6:0], 1'b0};
            delay_count_next = i2cbm_pkg::wait_delay(i2cbm_pkg::UNITS_2, cfg.ticks_per_us);
            phase_next       = i2cbm_pkg::PH_WR_HI;
          end
          i2cbm_pkg::CMD_WACK: begin
            sda_dir_next       = 1'b0;
            sda_level_next     = 1'b1;
            timeout_count_next = 16'd0;
            delay_count_next   = i2cbm_pkg::wait_delay(i2cbm_pkg::UNITS_1, cfg.ticks_per_us);
            phase_next         = i2cbm_pkg::PH_AK_HI;
          end
          i2cbm_pkg::CMD_READ: begin
            sda_dir_next     = 1'b0;
            shift_reg_next   = 8'd0;
            bit_count_next   = 4'd0;
            ack_choice_next  = step_in.send_ack;
            scl_level_next   = 1'b0;
            delay_count_next = i2cbm_pkg::wait_delay(i2cbm_pkg::UNITS_2, cfg.ticks_per_us);
            phase_next       = i2cbm_pkg::PH_RD_HI;
          end
          default: begin
          end
        endcase
      end
    end else if (delay_count != 10'd0) begin
      delay_count_next = delay_count - 10'd1;
    end else begin
      case (phase)
        i2cbm_pkg::PH_ST_LOW: begin
          sda_level_next   = 1'b0;
          delay_count_next = i2cbm_pkg::wait_delay(i2cbm_pkg::UNITS_4, cfg.ticks_per_us);
          phase_next       = i2cbm_pkg::PH_ST_END;
        end
        i2cbm_pkg::PH_ST_END: begin
          scl_level_next = 1'b0;
          phase_next     = i2cbm_pkg::PH_IDLE;
          done_next      = 1'b1;
        end
        i2cbm_pkg::PH_SP_HIGH: begin
          scl_level_next   = 1'b1;
          sda_level_next   = 1'b1;
          delay_count_next = i2cbm_pkg::wait_delay(i2cbm_pkg::UNITS_4, cfg.ticks_per_us);
          phase_next       = i2cbm_pkg::PH_SP_END;
        end
        i2cbm_pkg::PH_SP_END: begin
          phase_next = i2cbm_pkg::PH_IDLE;
          done_next  = 1'b1;
        end
        i2cbm_pkg::PH_WR_HI: begin
          scl_level_next   = 1'b1;
          delay_count_next = i2cbm_pkg::wait_delay(i2cbm_pkg::UNITS_2, cfg.ticks_per_us);
          phase_next       = i2cbm_pkg::PH_WR_LO;
        end
        i2cbm_pkg::PH_WR_LO: begin
          scl_level_next   = 1'b0;
          delay_count_next = i2cbm_pkg::wait_delay(i2cbm_pkg::UNITS_2, cfg.ticks_per_us);
          bit_count_next   = bit_count_inc;
          phase_next       = i2cbm_pkg::PH_WR_NEXT;
        end
        i2cbm_pkg::PH_WR_NEXT: begin
          if (bit_count >= i2cbm_pkg::BITS_PER_BYTE) begin
            phase_next = i2cbm_pkg::PH_IDLE;
            done_next  = 1'b1;
          end else begin
            sda_level_next   = shift_reg[7];
            shift_reg_next   = {shift_reg[6:0], 1'b0};
            delay_count_next = i2cbm_pkg::wait_delay(i2cbm_pkg::UNITS_2, cfg.ticks_per_us);
            phase_next       = i2cbm_pkg::PH_WR_HI;
          end
        end
        i2cbm_pkg::PH_AK_HI: begin
          scl_level_next   = 1'b1;
          delay_count_next = i2cbm_pkg::wait_delay(i2cbm_pkg::UNITS_1, cfg.ticks_per_us);
          phase_next       = i2cbm_pkg::PH_AK_POLL;
        end
        i2cbm_pkg::PH_AK_POLL: begin
          if (!step_in.sda_in) begin
            scl_level_next = 1'b0;
            fail_flag_next = 1'b0;
            phase_next     = i2cbm_pkg::PH_IDLE;
            done_next      = 1'b1;
          end else if (timeout_count >= cfg.ack_timeout) begin
            // No acknowledge: flag it and release the bus with a stop
            fail_flag_next   = 1'b1;
            sda_dir_next     = 1'b1;
            scl_level_next   = 1'b0;
            sda_level_next   = 1'b0;
            delay_count_next = i2cbm_pkg::wait_delay(i2cbm_pkg::UNITS_4, cfg.ticks_per_us);
            phase_next       = i2cbm_pkg::PH_SP_HIGH;
          end else begin
            timeout_count_next = timeout_count + 16'd1;
          end
        end
        i2cbm_pkg::PH_RD_HI: begin
          scl_level_next   = 1'b1;
          delay_count_next = i2cbm_pkg::wait_delay(i2cbm_pkg::UNITS_1, cfg.ticks_per_us);
          phase_next       = i2cbm_pkg::PH_RD_SMP;
        end
        i2cbm_pkg::PH_RD_SMP: begin
          shift_reg_next   = {shift_reg[6:0], step_in.sda_in};
          bit_count_next   = bit_count_inc;
          scl_level_next   = 1'b0;
          delay_count_next = i2cbm_pkg::wait_delay(i2cbm_pkg::UNITS_2, cfg.ticks_per_us);
          if (bit_count_inc < i2cbm_pkg::BITS_PER_BYTE) begin
            phase_next = i2cbm_pkg::PH_RD_HI;
          end else begin
            sda_dir_next   = 1'b1;
            sda_level_next = ~ack_choice;
            phase_next     = i2cbm_pkg::PH_RK_HI;
          end
        end
        i2cbm_pkg::PH_RK_HI: begin
          scl_level_next   = 1'b1;
          delay_count_next = i2cbm_pkg::wait_delay(i2cbm_pkg::UNITS_2, cfg.ticks_per_us);
          phase_next       = i2cbm_pkg::PH_RK_END;
        end
        i2cbm_pkg::PH_RK_END: begin
          scl_level_next     = 1'b0;
          received_byte_next = shift_reg;
          phase_next         = i2cbm_pkg::PH_IDLE;
          done_next          = 1'b1;
        end
        default: begin
          phase_next = i2cbm_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= i2cbm_pkg::PH_IDLE;
      delay_count   <= 10'd0;
      bit_count     <= 4'd0;
      shift_reg     <= 8'd0;
      timeout_count <= 16'd0;
      scl_level     <= 1'b1;
      sda_level     <= 1'b1;
      sda_dir       <= 1'b1;
      received_byte <= 8'd0;
      fail_flag     <= 1'b0;
      ack_choice    <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      delay_count   <= delay_count_next;
      bit_count     <= bit_count_next;
      shift_reg     <= shift_reg_next;
      timeout_count <= timeout_count_next;
      scl_level     <= scl_level_next;
      sda_level     <= sda_level_next;
      sda_dir       <= sda_dir_next;
      received_byte <= received_byte_next;
      fail_flag     <= fail_flag_next;
      ack_choice    <= ack_choice_next;
    end
  end

  assign res_next.scl_out      = scl_level_next;
  assign res_next.sda_out      = sda_level_next;
  assign res_next.sda_drive_en = sda_dir_next;
  assign res_next.busy_res     = (phase_next != i2cbm_pkg::PH_IDLE);
  assign res_next.done_res     = done_next;
  assign res_next.rx_byte      = received_byte_next;
  assign res_next.ack_failed   = fail_flag_next;

  `CHK_NOW(a_idle_no_delay, clk, rst, phase == i2cbm_pkg::PH_IDLE, delay_count == 10'd0,
    "idle with delay pending")
  `CHK_NOW(a_bit_count_range, clk, rst, 1'b1, bit_count <= i2cbm_pkg::BITS_PER_BYTE,
    "bit counter past one byte")

endmodule

FILE: design/i2c_bit_level_master_top.sv
// ----------------------------------------------------------------------------
// I2C bit-level master, top level
// Tick-driven SCL/SDA sequencer with input and result registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transfer per clock tick of the
//   pin sequencer, carrying the sampled SDA level and an optional command
//   (start, stop, write byte, wait ack, read byte plus ACK/NACK).
//   Output channel (out_valid / out_stall): exactly one result transfer per
//   input transfer, in order: pin levels, busy, done pulse, rx byte, ack fail.
//   Config channel (cfg_valid / cfg_ready): index 0 is ticks per microsecond,
//   index 1 the acknowledge timeout; write only while the block is idle.
// Path: the input register holds a taken item, the sequencer step reads it
//   combinationally, and the result register loads its result when the
//   step fires; a stalled output can hold the item in the input register.
// Throughput: one item per cycle while the output is not stalled, set by the
//   combinational sequencer step between the two registers.
// Reset: synchronous, clears the sequencer to idle with SCL and SDA high and
//   SDA driven, and restores the register defaults (8 and 250).
// Stall: a stalled result holds; the input register still takes an item while
//   empty, and in_stall is high while it holds one and the output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2c_bit_level_master_top (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd_valid,
  input  logic [2:0]  cmd,
  input  logic [7:0]  tx_byte,
  input  logic        send_ack,
  input  logic        sda_in,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_out,
  output logic        sda_out,
  output logic        sda_drive_en,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  rx_byte,
  output logic        ack_failed,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  i2cbm_pkg::cfg_t     cfg;
  i2cbm_pkg::step_in_t in_reg;
  i2cbm_pkg::result_t  res_next;
  i2cbm_pkg::result_t  res_reg;
  logic                in_reg_valid;
  logic                fire;
  logic                in_take;

  // Step the sequencer when an item waits and the result slot is free or draining
  assign fire     = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !fire;
  assign in_take  = in_valid && !in_stall;

  // Input register: hold the item until the sequencer consumes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_take) begin
      in_reg_valid <= 1'b1;
    end else if (fire) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_reg.cmd_valid <= cmd_valid;
      in_reg.cmd       <= cmd;
      in_reg.tx_byte   <= tx_byte;
      in_reg.send_ack  <= send_ack;
      in_reg.sda_in    <= sda_in;
    end
  end

  i2cbm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i2cbm_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .step_in  (in_reg),
    .cfg      (cfg),
    .res_next (res_next)
  );

  // Result register: load on each sequencer step, drop once the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_reg <= res_next;
    end
  end

  assign scl_out      = res_reg.scl_out;
  assign sda_out      = res_reg.sda_out;
  assign sda_drive_en = res_reg.sda_drive_en;
  assign busy_res     = res_reg.busy_res;
  assign done_res     = res_reg.done_res;
  assign rx_byte      = res_reg.rx_byte;
  assign ack_failed   = res_reg.ack_failed;

  `CHK_NOW(a_stall_needs_item, clk, rst, in_stall, in_reg_valid,
    "input stalled with empty input register")
  `CHK_NEXT(a_fire_gives_result, clk, rst, fire, out_valid,
    "sequencer step produced no result")
  `CHK_NOW(a_done_means_idle, clk, rst, out_valid && done_res, !busy_res,
    "done pulse while still busy")

endmodule

FILE: tb/tb_i2c_bit_level_master_top.sv
// ----------------------------------------------------------------------------
// Testbench for the I2C bit-level master
// Streams clock ticks with commands and sampled SDA into the sequencer, tracks
// the expected pin levels, busy, done, rx byte and ack-fail flag per tick in a
// local sequencer model, and checks every result transfer in order. Runs a
// directed pass and then random, mostly well-formed bus sequences under several
// register settings and idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_i2c_bit_level_master_top;

  localparam int QUIET_LIMIT = 5000;

  // How sda_in behaves on filler ticks while a command runs
  typedef enum logic [1:0] {
    SDA_RANDOM,
    SDA_HELD_HIGH,
    SDA_HELD_LOW,
    SDA_ACK_SOON
  } sda_plan_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd_valid = 1'b0;
  logic [2:0]  cmd = i2cbm_pkg::CMD_START;
  logic [7:0]  tx_byte = 8'd0;
  logic        send_ack = 1'b0;
  logic        sda_in = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        scl_out;
  logic        sda_out;
  logic        sda_drive_en;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  rx_byte;
  logic        ack_failed;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = i2cbm_pkg::CFG_TICKS_PER_US;
  logic [15:0] cfg_data = 16'd0;

  i2c_bit_level_master_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .tx_byte      (tx_byte),
    .send_ack     (send_ack),
    .sda_in       (sda_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .scl_out      (scl_out),
    .sda_out      (sda_out),
    .sda_drive_en (sda_drive_en),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .rx_byte      (rx_byte),
    .ack_failed   (ack_failed),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Ticks waiting to be driven, and pin results waiting to come out
  i2cbm_pkg::step_in_t tick_queue[$];
  i2cbm_pkg::result_t  pin_results_due[$];

  int        mismatches = 0;
  int        cmds_in_flight = 0;   // ticks with cmd_valid pushed but not yet taken
  int        ticks_pushed = 0;
  int        send_gap_pct = 0;
  int        stall_pct = 0;
  int        quiet_cycles = 0;
  sda_plan_t sda_plan = SDA_RANDOM;
  logic [2:0] last_cmd = i2cbm_pkg::CMD_STOP;

  // --------------------------------------------------------------------------
  // Sequencer model: register settings and state, as after reset
  // --------------------------------------------------------------------------
  logic [7:0]  cfg_tpu = i2cbm_pkg::TICKS_PER_US_RST;
  logic [15:0] cfg_tmo = i2cbm_pkg::ACK_TIMEOUT_RST;

  logic [3:0]  seq_ph    = i2cbm_pkg::PH_IDLE;
  logic [9:0]  seq_dly   = 10'd0;
  logic [3:0]  seq_bits  = 4'd0;
  logic [7:0]  seq_shift = 8'd0;
  logic [15:0] seq_polls = 16'd0;
  logic        seq_scl   = 1'b1;
  logic        seq_sda   = 1'b1;
  logic        seq_dir   = 1'b1;
  logic [7:0]  seq_rx    = 8'd0;
  logic        seq_fail  = 1'b0;
  logic        seq_ackc  = 1'b0;
  logic        seq_done  = 1'b0;

  // Load the delay counter so the next action comes n units later, never
  // sooner than the next tick.
  function automatic void hold_units(int unsigned n);
    int unsigned d;
    d = n * cfg_tpu;
    if (d == 0) d = 1;
    seq_dly = 10'(d - 1);
  endfunction

  function automatic void end_cmd();
    seq_ph   = i2cbm_pkg::PH_IDLE;
    seq_done = 1'b1;
  endfunction

  // Pull SCL and SDA low, then release them in stop order.
  function automatic void enter_stop();
    seq_dir = 1'b1;
    seq_scl = 1'b0;
    seq_sda = 1'b0;
    hold_units(4);
    seq_ph = i2cbm_pkg::PH_SP_HIGH;
  endfunction

  function automatic void send_bit();
    seq_sda   = seq_shift[7];
    seq_shift = seq_shift << 1;
    hold_units(2);
    seq_ph = i2cbm_pkg::PH_WR_HI;
  endfunction

  // Advance the model by one tick and return the levels after it.
  function automatic i2cbm_pkg::result_t sequencer_tick(i2cbm_pkg::step_in_t t);
    i2cbm_pkg::result_t r;
    seq_done = 1'b0;
    if (seq_ph == i2cbm_pkg::PH_IDLE) begin
      if (t.cmd_valid) begin
        case (t.cmd)
          i2cbm_pkg::CMD_START: begin
            seq_dir = 1'b1; seq_sda = 1'b1; seq_scl = 1'b1;
            hold_units(4); seq_ph = i2cbm_pkg::PH_ST_LOW;
          end
          i2cbm_pkg::CMD_STOP: enter_stop();
          i2cbm_pkg::CMD_WRITE: begin
            seq_dir = 1'b1; seq_scl = 1'b0;
            seq_shift = t.tx_byte; seq_bits = 4'd0;
            send_bit();
          end
          i2cbm_pkg::CMD_WACK: begin
            seq_dir = 1'b0; seq_sda = 1'b1; seq_polls = 16'd0;
            hold_units(1); seq_ph = i2cbm_pkg::PH_AK_HI;
          end
          i2cbm_pkg::CMD_READ: begin
            seq_dir = 1'b0; seq_shift = 8'd0; seq_bits = 4'd0;
            seq_ackc = t.send_ack; seq_scl = 1'b0;
            hold_units(2); seq_ph = i2cbm_pkg::PH_RD_HI;
          end
          default: ;
        endcase
      end
    end else if (seq_dly != 10'd0) begin
      seq_dly = seq_dly - 10'd1;
    end else begin
      case (seq_ph)
        i2cbm_pkg::PH_ST_LOW: begin
          seq_sda = 1'b0; hold_units(4); seq_ph = i2cbm_pkg::PH_ST_END;
        end
        i2cbm_pkg::PH_ST_END: begin
          seq_scl = 1'b0; end_cmd();
        end
        i2cbm_pkg::PH_SP_HIGH: begin
          seq_scl = 1'b1; seq_sda = 1'b1; hold_units(4);
          seq_ph = i2cbm_pkg::PH_SP_END;
        end
        i2cbm_pkg::PH_SP_END: end_cmd();
        i2cbm_pkg::PH_WR_HI: begin
          seq_scl = 1'b1; hold_units(2); seq_ph = i2cbm_pkg::PH_WR_LO;
        end
        i2cbm_pkg::PH_WR_LO: begin
          seq_scl = 1'b0; hold_units(2);
          seq_bits = seq_bits + 4'd1; seq_ph = i2cbm_pkg::PH_WR_NEXT;
        end
        i2cbm_pkg::PH_WR_NEXT: begin
          if (seq_bits >= i2cbm_pkg::BITS_PER_BYTE) end_cmd();
          else send_bit();
        end
        i2cbm_pkg::PH_AK_HI: begin
          seq_scl = 1'b1; hold_units(1); seq_ph = i2cbm_pkg::PH_AK_POLL;
        end
        i2cbm_pkg::PH_AK_POLL: begin
          if (!t.sda_in) begin
            seq_scl = 1'b0; seq_fail = 1'b0; end_cmd();
          end else if (seq_polls >= cfg_tmo) begin
            seq_fail = 1'b1; enter_stop();
          end else begin
            seq_polls = seq_polls + 16'd1;
          end
        end
        i2cbm_pkg::PH_RD_HI: begin
          seq_scl = 1'b1; hold_units(1); seq_ph = i2cbm_pkg::PH_RD_SMP;
        end
        i2cbm_pkg::PH_RD_SMP: begin
          seq_shift = {seq_shift[6:0], t.sda_in};
          seq_bits  = seq_bits + 4'd1;
          seq_scl   = 1'b0;
          if (seq_bits < i2cbm_pkg::BITS_PER_BYTE) begin
            hold_units(2); seq_ph = i2cbm_pkg::PH_RD_HI;
          end else begin
            seq_dir = 1'b1; seq_sda = !seq_ackc;
            hold_units(2); seq_ph = i2cbm_pkg::PH_RK_HI;
          end
        end
        i2cbm_pkg::PH_RK_HI: begin
          seq_scl = 1'b1; hold_units(2); seq_ph = i2cbm_pkg::PH_RK_END;
        end
        i2cbm_pkg::PH_RK_END: begin
          seq_scl = 1'b0; seq_rx = seq_shift; end_cmd();
        end
        default: seq_ph = i2cbm_pkg::PH_IDLE;
      endcase
    end
    r.scl_out      = seq_scl;
    r.sda_out      = seq_sda;
    r.sda_drive_en = seq_dir;
    r.busy_res     = (seq_ph != i2cbm_pkg::PH_IDLE);
    r.done_res     = seq_done;
    r.rx_byte      = seq_rx;
    r.ack_failed   = seq_fail;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Driver: take a tick from the queue when the current transfer is done and no gap is drawn.
  // Run the model on each tick the block accepts, so the model is always in
  // step with what the block has seen.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    i2cbm_pkg::step_in_t nxt;
    i2cbm_pkg::step_in_t taken;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        taken.cmd_valid = cmd_valid;
        taken.cmd       = cmd;
        taken.tx_byte   = tx_byte;
        taken.send_ack  = send_ack;
        taken.sda_in    = sda_in;
        pin_results_due.push_back(sequencer_tick(taken));
        if (cmd_valid) cmds_in_flight--;
      end
      // Hold the payload while stalled; otherwise load the next tick or idle.
      if (!in_valid || !in_stall) begin
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
          in_valid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          nxt = tick_queue.pop_front();
          in_valid  <= 1'b1;
          cmd_valid <= nxt.cmd_valid;
          cmd       <= nxt.cmd;
          tx_byte   <= nxt.tx_byte;
          send_ack  <= nxt.send_ack;
          sda_in    <= nxt.sda_in;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest expectation, and
  // drive the receiver stall for the next cycle.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    i2cbm_pkg::result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pin_results_due.size() == 0) begin
          report_mismatch("result with nothing due", 1, 0);
        end else begin
          want = pin_results_due.pop_front();
          if (scl_out !== want.scl_out)
            report_mismatch("scl_out", scl_out, want.scl_out);
          if (sda_out !== want.sda_out)
            report_mismatch("sda_out", sda_out, want.sda_out);
          if (sda_drive_en !== want.sda_drive_en)
            report_mismatch("sda_drive_en", sda_drive_en, want.sda_drive_en);
          if (busy_res !== want.busy_res)
            report_mismatch("busy_res", busy_res, want.busy_res);
          if (done_res !== want.done_res)
            report_mismatch("done_res", done_res, want.done_res);
          if (rx_byte !== want.rx_byte)
            report_mismatch("rx_byte", rx_byte, want.rx_byte);
          if (ack_failed !== want.ack_failed)
            report_mismatch("ack_failed", ack_failed, want.ack_failed);
        end
      end
      out_stall <= (stall_pct != 0 && $urandom_range(0, 99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no channel moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic pick_sda();
    case (sda_plan)
      SDA_HELD_HIGH: return 1'b1;
      SDA_HELD_LOW:  return 1'b0;
      SDA_ACK_SOON:  return ($urandom_range(0, 5) != 0);
      default:       return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic push_tick(logic cv, logic [2:0] c, logic [7:0] tx, logic ack, logic sda);
    i2cbm_pkg::step_in_t t;
    t.cmd_valid = cv;
    t.cmd       = c;
    t.tx_byte   = tx;
    t.send_ack  = ack;
    t.sda_in    = sda;
    tick_queue.push_back(t);
    ticks_pushed++;
    if (cv) cmds_in_flight++;
  endtask

  // Keep the sequencer fed with ticks until it is idle and no command is
  // still on its way. Filler ticks carry random junk in the command fields;
  // now and then a command lands while busy and must be ignored.
  task automatic feed_until_idle();
    @(negedge clk);
    while (seq_ph != i2cbm_pkg::PH_IDLE || cmds_in_flight != 0) begin
      if (tick_queue.size() < 2)
        push_tick($urandom_range(0, 39) == 0, 3'($urandom_range(0, 7)),
                  8'($urandom), 1'($urandom), pick_sda());
      @(negedge clk);
    end
  endtask

  // Wait for an idle sequencer, then send one command.
  task automatic issue(logic [2:0] c, logic [7:0] tx, logic ack, sda_plan_t plan);
    feed_until_idle();
    sda_plan = plan;
    while (tick_queue.size() >= 2) @(negedge clk);
    push_tick(1'b1, c, tx, ack, pick_sda());
  endtask

  // Drain everything and leave the block idle for a register write.
  task automatic settle();
    feed_until_idle();
    while (tick_queue.size() != 0 || in_valid || pin_results_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers back to back; call right after a rising edge.
  task automatic write_regs(logic [15:0] tpu_word, logic [15:0] tmo_word);
    cfg_valid <= 1'b1;
    cfg_index <= i2cbm_pkg::CFG_TICKS_PER_US;
    cfg_data  <= tpu_word;
    do @(posedge clk); while (!cfg_ready);
    cfg_tpu = tpu_word[7:0];
    cfg_index <= i2cbm_pkg::CFG_ACK_TIMEOUT;
    cfg_data  <= tmo_word;
    do @(posedge clk); while (!cfg_ready);
    cfg_tmo = tmo_word;
    cfg_valid <= 1'b0;
  endtask

  // Pick the next command so that most traffic forms proper bus sequences:
  // start, address write, ack, data writes or reads, stop.
  function automatic logic [2:0] choose_cmd();
    if ($urandom_range(0, 9) == 0) return 3'($urandom_range(0, 7));
    case (last_cmd)
      i2cbm_pkg::CMD_START: return i2cbm_pkg::CMD_WRITE;
      i2cbm_pkg::CMD_WRITE: return i2cbm_pkg::CMD_WACK;
      i2cbm_pkg::CMD_WACK: begin
        if (seq_fail) return i2cbm_pkg::CMD_START;
        case ($urandom_range(0, 3))
          0: return i2cbm_pkg::CMD_WRITE;
          1: return i2cbm_pkg::CMD_READ;
          2: return i2cbm_pkg::CMD_STOP;
          default: return i2cbm_pkg::CMD_START;
        endcase
      end
      i2cbm_pkg::CMD_READ:
        return ($urandom_range(0, 2) != 0) ? i2cbm_pkg::CMD_READ : i2cbm_pkg::CMD_STOP;
      default: return i2cbm_pkg::CMD_START;
    endcase
  endfunction

  // Send random commands until about n_ticks more ticks have been queued.
  task automatic run_random(logic [15:0] tpu_word, logic [15:0] tmo_word,
                            int gap, int stall, int n_ticks);
    int stop_at;
    logic [2:0] c;
    sda_plan_t plan;
    settle();
    write_regs(tpu_word, tmo_word);
    send_gap_pct = gap;
    stall_pct    = stall;
    stop_at = ticks_pushed + n_ticks;
    while (ticks_pushed < stop_at) begin
      // Look at the model only once the previous command has finished.
      feed_until_idle();
      c = choose_cmd();
      plan = SDA_RANDOM;
      if (c == i2cbm_pkg::CMD_WACK)
        plan = (cfg_tmo <= 16'd300 && $urandom_range(0, 4) == 0) ? SDA_HELD_HIGH
                                                                 : SDA_ACK_SOON;
      issue(c, 8'($urandom), 1'($urandom), plan);
      if (c <= i2cbm_pkg::CMD_READ) last_cmd = c;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: a start with a stop sent while it is still running,
    // then a real stop.
    issue(i2cbm_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM);
    push_tick(1'b1, i2cbm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b1);
    issue(i2cbm_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);

    // Zero ticks per unit (every wait is one tick, upper data bits ignored)
    // and zero timeout (the first high poll fails): byte extremes, ack seen
    // and ack timed out, reads of all ones, all zeros and random data with
    // ACK and NACK, and undefined command codes.
    settle();
    write_regs(16'hAB00, 16'd0);
    issue(i2cbm_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM);
    issue(i2cbm_pkg::CMD_WRITE, 8'h00, 1'b0, SDA_RANDOM);
    issue(i2cbm_pkg::CMD_WACK,  8'h00, 1'b0, SDA_HELD_HIGH);
    issue(i2cbm_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM);
    issue(i2cbm_pkg::CMD_WRITE, 8'hFF, 1'b1, SDA_RANDOM);
    issue(i2cbm_pkg::CMD_WACK,  8'h00, 1'b0, SDA_HELD_LOW);
    issue(i2cbm_pkg::CMD_READ,  8'h00, 1'b1, SDA_RANDOM);
    issue(i2cbm_pkg::CMD_READ,  8'h00, 1'b0, SDA_HELD_HIGH);
    issue(i2cbm_pkg::CMD_READ,  8'hFF, 1'b1, SDA_HELD_LOW);
    issue(3'd5, 8'h12, 1'b1, SDA_RANDOM);
    issue(3'd6, 8'h34, 1'b0, SDA_RANDOM);
    issue(3'd7, 8'h56, 1'b1, SDA_RANDOM);
    issue(i2cbm_pkg::CMD_STOP,  8'h00, 1'b0, SDA_RANDOM);

    // Random bus traffic: no idling, sender gaps, receiver stalls, both.
    run_random(16'd1,    16'd1, 0,  0,  110);
    run_random(16'd2,    16'd4, 48, 0,  110);
    run_random(16'hFF00, 16'd6, 0,  48, 110);
    run_random(16'hFF01, 16'd3, 25, 25, 110);

    // Drain and let any stray result show up before the verdict.
    settle();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/i2cbm_pkg.sv
design/i2cbm_cfg.sv
design/i2cbm_core.sv
design/i2c_bit_level_master_top.sv
tb/tb_i2c_bit_level_master_top.sv
